@@ hw/rtl/paired_chunk_page_allocator_unit_defines.svh @@
// Assertion macros used by the allocator datapath (pcpa_dp).
`ifndef PAIRED_CHUNK_PAGE_ALLOCATOR_UNIT_DEFINES_SVH
`define PAIRED_CHUNK_PAGE_ALLOCATOR_UNIT_DEFINES_SVH

// Clocked check, off while reset is asserted.
`define PCPA_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Clocked check that also holds during reset.
`define PCPA_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ hw/rtl/pcpa_pkg.sv @@
// ----------------------------------------------------------------------------
// pcpa_pkg
// Shared constants, codes and control types of the paired chunk page allocator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package pcpa_pkg;

	localparam int NUM_PAGES   = 64;
	localparam int PG_W        = 6;
	localparam int CNT_W       = 7;
	localparam int CHUNK_ORDER = 6;
	localparam int PAGE_BITS   = 12;
	localparam int BLK_SHIFT   = PAGE_BITS - CHUNK_ORDER;
	localparam int BLK_BYTES   = 1 << BLK_SHIFT;
	localparam int PAGE_SIZE_B = 1 << PAGE_BITS;
	localparam int NCHUNKS     = (1 << CHUNK_ORDER) - 1;
	localparam int MAX_REQ     = PAGE_SIZE_B - 2 * BLK_BYTES;
	localparam int STAMP_W     = 32;

	localparam logic [2:0] ST_OK      = 3'd0;
	localparam logic [2:0] ST_INVALID = 3'd1;
	localparam logic [2:0] ST_NOSPACE = 3'd2;
	localparam logic [2:0] ST_NOMEM   = 3'd3;
	localparam logic [2:0] ST_BADFREE = 3'd4;

	localparam logic CMD_ALLOC = 1'b0;

	typedef enum logic [2:0] {
		S_IDLE,
		S_DECODE,
		S_SCAN,
		S_SCAN_END,
		S_ALLOC_WR,
		S_FREE_RD,
		S_FREE_WR,
		S_RESP
	} state_t;

	typedef struct packed {
		logic load;
		logic reject;
		logic scan_start;
		logic scan_step;
		logic alloc_wr;
		logic free_rd;
		logic free_wr;
		logic out_load;
	} ctrl_t;

	typedef struct packed {
		logic is_alloc;
		logic is_free;
		logic scan_last;
		logic out_free;
	} stat_t;

endpackage
`default_nettype wire

@@ hw/rtl/pcpa_ctrl.sv @@
// ----------------------------------------------------------------------------
// pcpa_ctrl
// Sequencer: decode, page table scan, read-modify-write and result handoff.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module pcpa_ctrl (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            in_fire,
	input  pcpa_pkg::stat_t      stat,
	output logic                 in_ready,
	output pcpa_pkg::ctrl_t      ctrl
);

	pcpa_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pcpa_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		ctrl     = '0;
		in_ready = 1'b0;
		unique case (state_q)
			pcpa_pkg::S_IDLE: begin
				in_ready  = 1'b1;
				ctrl.load = in_fire;
				if (in_fire) state_d = pcpa_pkg::S_DECODE;
			end
			pcpa_pkg::S_DECODE: begin
				if (stat.is_alloc) begin
					ctrl.scan_start = 1'b1;
					state_d         = pcpa_pkg::S_SCAN;
				end else if (stat.is_free) begin
					state_d = pcpa_pkg::S_FREE_RD;
				end else begin
					// rejected alloc: go straight to the result
					ctrl.reject = 1'b1;
					state_d     = pcpa_pkg::S_RESP;
				end
			end
			pcpa_pkg::S_SCAN: begin
				ctrl.scan_step = 1'b1;
				if (stat.scan_last) state_d = pcpa_pkg::S_SCAN_END;
			end
			pcpa_pkg::S_SCAN_END: state_d = pcpa_pkg::S_ALLOC_WR;
			pcpa_pkg::S_ALLOC_WR: begin
				ctrl.alloc_wr = 1'b1;
				state_d       = pcpa_pkg::S_RESP;
			end
			pcpa_pkg::S_FREE_RD: begin
				ctrl.free_rd = 1'b1;
				state_d      = pcpa_pkg::S_FREE_WR;
			end
			pcpa_pkg::S_FREE_WR: begin
				ctrl.free_wr = 1'b1;
				state_d      = pcpa_pkg::S_RESP;
			end
			pcpa_pkg::S_RESP: begin
				if (stat.out_free) begin
					ctrl.out_load = 1'b1;
					state_d       = pcpa_pkg::S_IDLE;
				end
			end
			default: state_d = pcpa_pkg::S_IDLE;
		endcase
	end

endmodule
`default_nettype wire

@@ hw/rtl/pcpa_dp.sv @@
// ----------------------------------------------------------------------------
// pcpa_dp
// Datapath: page table memory, best-fit scan, update and output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "paired_chunk_page_allocator_unit_defines.svh"
module pcpa_dp (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  pcpa_pkg::ctrl_t                        ctrl,
	output pcpa_pkg::stat_t                        stat,
	input  wire logic                              in_cmd,
	input  wire logic [15:0]                       in_size,
	input  wire logic                              in_highmem,
	input  wire logic [pcpa_pkg::PG_W-1:0]         in_fpage,
	input  wire logic                              in_fhalf,
	input  wire logic                              out_ready,
	output logic                                   out_valid,
	output logic [2:0]                             out_status,
	output logic [pcpa_pkg::PG_W-1:0]              out_page,
	output logic                                   out_half,
	output logic [pcpa_pkg::PAGE_BITS-1:0]         out_offset,
	output logic [pcpa_pkg::CNT_W-1:0]             out_count
);

	localparam int CW = pcpa_pkg::CHUNK_ORDER;
	localparam int SW = pcpa_pkg::STAMP_W;
	localparam int PW = pcpa_pkg::PG_W;

	typedef struct packed {
		logic [CW-1:0] first;
		logic [CW-1:0] last;
		logic [SW-1:0] stamp;
	} entry_t;

	entry_t mem [pcpa_pkg::NUM_PAGES];
	logic [pcpa_pkg::NUM_PAGES-1:0] valid_q;

	logic          cmd_q, hm_q, fhalf_q;
	logic [15:0]   size_q;
	logic [PW-1:0] fpage_q;

	logic [SW-1:0]                 stamp_q;
	logic [pcpa_pkg::CNT_W-1:0]    count_q;
	logic [PW-1:0]                 ctr_q;

	entry_t        rd_s1;
	logic          rd_vld_s1, eval_s1;
	logic [PW-1:0] rd_addr_s1;

	logic          found_q, empty_found_q;
	logic [PW-1:0] best_page_q, empty_page_q;
	logic [CW-1:0] best_fc_q, best_f_q, best_l_q;
	logic [SW-1:0] best_age_q;

	logic [2:0]                    res_status_q;
	logic [PW-1:0]                 res_page_q;
	logic                          res_half_q;
	logic [pcpa_pkg::PAGE_BITS-1:0] res_off_q;

	logic          ov_q;
	logic [2:0]    os_q;
	logic [PW-1:0] op_q;
	logic          oh_q;
	logic [pcpa_pkg::PAGE_BITS-1:0] oo_q;
	logic [pcpa_pkg::CNT_W-1:0]     oc_q;

	logic [16:0]   rounded;
	logic [CW-1:0] chunks;
	logic          bad_req, no_space;
	entry_t        cur;
	logic [CW-1:0] fc;
	logic [SW-1:0] age;
	logic          half_used, cand;
	logic [PW-1:0] rd_addr;

	assign rounded  = {1'b0, size_q} + 17'(pcpa_pkg::BLK_BYTES - 1);
	assign chunks   = rounded[pcpa_pkg::BLK_SHIFT +: CW];
	assign bad_req  = (size_q == 16'd0) || hm_q;
	assign no_space = 17'(size_q) > 17'(pcpa_pkg::MAX_REQ);

	// an entry never written reads as empty
	assign cur       = rd_vld_s1 ? rd_s1 : '0;
	assign half_used = (cur.first == '0) != (cur.last == '0);
	assign fc        = CW'(pcpa_pkg::NCHUNKS) - cur.first - cur.last;
	assign age       = stamp_q - cur.stamp;
	assign cand      = half_used && (fc >= chunks) &&
	                   (!found_q || (fc < best_fc_q) ||
	                    ((fc == best_fc_q) && (age < best_age_q)));
	assign rd_addr   = ctrl.free_rd ? fpage_q : ctr_q;

	assign stat.is_alloc  = (cmd_q == pcpa_pkg::CMD_ALLOC) && !bad_req && !no_space;
	assign stat.is_free   = cmd_q != pcpa_pkg::CMD_ALLOC;
	assign stat.scan_last = ctr_q == PW'(pcpa_pkg::NUM_PAGES - 1);
	assign stat.out_free  = !ov_q || out_ready;

	always_ff @(posedge clk) begin
		rd_s1      <= mem[rd_addr];
		rd_addr_s1 <= rd_addr;
		if (ctrl.load) begin
			cmd_q   <= in_cmd;
			size_q  <= in_size;
			hm_q    <= in_highmem;
			fpage_q <= in_fpage;
			fhalf_q <= in_fhalf;
		end
		if (eval_s1 && cand) begin
			best_page_q <= rd_addr_s1;
			best_fc_q   <= fc;
			best_age_q  <= age;
			best_f_q    <= cur.first;
			best_l_q    <= cur.last;
		end
		if (eval_s1 && !empty_found_q && cur.first == '0 && cur.last == '0)
			empty_page_q <= rd_addr_s1;
		if (ctrl.alloc_wr) begin
			if (found_q) begin
				mem[best_page_q] <= best_f_q == '0 ?
					entry_t'{chunks, best_l_q, stamp_q} : entry_t'{best_f_q, chunks, stamp_q};
			end else if (empty_found_q) begin
				mem[empty_page_q] <= entry_t'{chunks, '0, stamp_q};
			end
		end
		if (ctrl.free_wr && ((fhalf_q ? cur.last : cur.first) != '0)) begin
			mem[fpage_q] <= fhalf_q ? entry_t'{cur.first, '0, stamp_q}
			                        : entry_t'{'0, cur.last, stamp_q};
		end
		if (ctrl.out_load) begin
			os_q <= res_status_q;
			op_q <= res_page_q;
			oh_q <= res_half_q;
			oo_q <= res_off_q;
			oc_q <= count_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		logic [CW-1:0] sel;
		logic          last_b;
		if (!arst_n) begin
			valid_q       <= '0;
			stamp_q       <= '0;
			count_q       <= '0;
			ctr_q         <= '0;
			rd_vld_s1     <= 1'b0;
			eval_s1       <= 1'b0;
			found_q       <= 1'b0;
			empty_found_q <= 1'b0;
			ov_q          <= 1'b0;
			res_status_q  <= pcpa_pkg::ST_OK;
			res_page_q    <= '0;
			res_half_q    <= 1'b0;
			res_off_q     <= '0;
		end else begin
			sel       = fhalf_q ? cur.last : cur.first;
			last_b    = fhalf_q ? (cur.first == '0) : (cur.last == '0);
			rd_vld_s1 <= valid_q[rd_addr];
			eval_s1   <= ctrl.scan_step;
			if (ctrl.scan_start) begin
				ctr_q         <= '0;
				found_q       <= 1'b0;
				empty_found_q <= 1'b0;
			end else if (ctrl.scan_step) begin
				ctr_q <= ctr_q + PW'(1);
			end
			if (eval_s1 && cand) found_q <= 1'b1;
			if (eval_s1 && cur.first == '0 && cur.last == '0) empty_found_q <= 1'b1;
			if (ctrl.load) begin
				res_status_q <= pcpa_pkg::ST_OK;
				res_page_q   <= '0;
				res_half_q   <= 1'b0;
				res_off_q    <= '0;
			end
			// a rejected alloc or a free never reaches the scan
			if (ctrl.reject && !stat.is_alloc && cmd_q == pcpa_pkg::CMD_ALLOC)
				res_status_q <= bad_req ? pcpa_pkg::ST_INVALID : pcpa_pkg::ST_NOSPACE;
			if (ctrl.alloc_wr) begin
				if (found_q) begin
					res_page_q <= best_page_q;
					if (best_f_q == '0) begin
						res_half_q <= 1'b0;
						res_off_q  <= pcpa_pkg::PAGE_BITS'(pcpa_pkg::BLK_BYTES);
					end else begin
						res_half_q <= 1'b1;
						res_off_q  <= pcpa_pkg::PAGE_BITS'(pcpa_pkg::PAGE_SIZE_B) -
						              ({{(pcpa_pkg::PAGE_BITS - CW){1'b0}}, chunks}
						               << pcpa_pkg::BLK_SHIFT);
					end
				end else if (empty_found_q) begin
					valid_q[empty_page_q] <= 1'b1;
					res_page_q <= empty_page_q;
					res_half_q <= 1'b0;
					res_off_q  <= pcpa_pkg::PAGE_BITS'(pcpa_pkg::BLK_BYTES);
					count_q    <= count_q + pcpa_pkg::CNT_W'(1);
					stamp_q    <= stamp_q + SW'(1);
				end else begin
					res_status_q <= pcpa_pkg::ST_NOMEM;
				end
				if (found_q) valid_q[best_page_q] <= 1'b1;
			end
			if (ctrl.free_wr) begin
				if (sel == '0 || ({1'b0, fpage_q} >= (PW + 1)'(pcpa_pkg::NUM_PAGES))) begin
					res_status_q <= pcpa_pkg::ST_BADFREE;
				end else begin
					valid_q[fpage_q] <= 1'b1;
					if (last_b) count_q <= count_q - pcpa_pkg::CNT_W'(1);
					else        stamp_q <= stamp_q + SW'(1);
				end
			end
			if (ctrl.out_load)      ov_q <= 1'b1;
			else if (out_ready)     ov_q <= 1'b0;
		end
	end

	// free_wr writes back the entry only on a legal free
	always_comb begin
		out_valid  = ov_q;
		out_status = os_q;
		out_page   = op_q;
		out_half   = oh_q;
		out_offset = oo_q;
		out_count  = oc_q;
	end

	`PCPA_ASSERT(a_count_bound, count_q <= pcpa_pkg::CNT_W'(pcpa_pkg::NUM_PAGES), "page count overflow")
	`PCPA_ASSERT(a_scan_eval, ctrl.scan_step |=> eval_s1, "scan read not evaluated")
	`PCPA_ASSERT(a_stamp_step, (stamp_q == $past(stamp_q)) || (stamp_q == $past(stamp_q) + SW'(1)), "stamp jumped")

endmodule
`default_nettype wire

@@ hw/rtl/paired_chunk_page_allocator_unit.sv @@
// ----------------------------------------------------------------------------
// paired_chunk_page_allocator_unit
// Two-object-per-page allocator over 64 pages of 63 usable 64-byte chunks.
// ----------------------------------------------------------------------------
// One word in, one result word out. An alloc scans the page table one page
// per cycle through the single read port of the table memory, then writes
// the chosen entry back; a rejected alloc skips the scan, and a free does one
// read and one write. A new word is accepted once the previous result has
// been handed to the output register.
// All state is cleared at reset through per-page valid bits; no sweep runs.
`timescale 1ns / 1ps
`default_nettype none
module paired_chunk_page_allocator_unit (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [23:0] s_tdata,  // req_size[15:0], highmem_flag[16], free_page[22:17], free_half[23]
	input  wire logic        s_tuser,  // cmd
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [31:0]      m_tdata   // status[2:0], page_index[8:3], half[9], byte_offset[21:10], pages_in_use[28:22]
);

	pcpa_pkg::ctrl_t ctrl;
	pcpa_pkg::stat_t stat;
	logic [2:0]  st;
	logic [5:0]  pg;
	logic        hf;
	logic [11:0] off;
	logic [6:0]  cnt;

	pcpa_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_fire  (s_tvalid && s_tready),
		.stat     (stat),
		.in_ready (s_tready),
		.ctrl     (ctrl)
	);

	pcpa_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctrl       (ctrl),
		.stat       (stat),
		.in_cmd     (s_tuser),
		.in_size    (s_tdata[15:0]),
		.in_highmem (s_tdata[16]),
		.in_fpage   (s_tdata[22:17]),
		.in_fhalf   (s_tdata[23]),
		.out_ready  (m_tready),
		.out_valid  (m_tvalid),
		.out_status (st),
		.out_page   (pg),
		.out_half   (hf),
		.out_offset (off),
		.out_count  (cnt)
	);

	assign m_tdata = {3'b000, cnt, off, hf, pg, st};

endmodule
`default_nettype wire

@@ tb/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the paired chunk page allocator.
// ----------------------------------------------------------------------------
// Alloc and free words go in through the slave stream. A scoreboard keeps its
// own page table and predicts every result word. Both stream sides pause at
// random, and the output side holds off once for a long stretch.
`timescale 1ns / 1ps
`default_nettype none

typedef struct packed {
	logic [6:0]  pages_in_use;
	logic [11:0] byte_offset;
	logic        half;
	logic [5:0]  page_index;
	logic [2:0]  status;
} alloc_result_t;

class alloc_scoreboard;
	int unsigned head_units[pcpa_pkg::NUM_PAGES];
	int unsigned tail_units[pcpa_pkg::NUM_PAGES];
	bit [31:0]   place_stamp[pcpa_pkg::NUM_PAGES];
	bit [31:0]   stamp_count;
	int unsigned used_pages;
	alloc_result_t pending[$];
	int errors;
	int checked;

	function void clear();
		for (int p = 0; p < pcpa_pkg::NUM_PAGES; p++) begin
			head_units[p] = 0;
			tail_units[p] = 0;
			place_stamp[p] = 0;
		end
		stamp_count = 0;
		used_pages = 0;
		errors = 0;
		checked = 0;
	endfunction

	function void stamp_page(int p);
		place_stamp[p] = stamp_count;
		stamp_count = stamp_count + 1;
	endfunction

	function alloc_result_t place_object(int unsigned size, bit highmem);
		alloc_result_t r;
		int unsigned chunks, fc;
		int best;
		int unsigned best_fc;
		bit [31:0] age, best_age;
		bit found;
		r = '0;
		best = 0;
		best_fc = 0;
		best_age = 0;
		found = 0;
		if (size == 0 || highmem) begin
			r.status = pcpa_pkg::ST_INVALID;
		end else if (size > pcpa_pkg::MAX_REQ) begin
			r.status = pcpa_pkg::ST_NOSPACE;
		end else begin
			chunks = (size + pcpa_pkg::BLK_BYTES - 1) >> pcpa_pkg::BLK_SHIFT;
			for (int p = 0; p < pcpa_pkg::NUM_PAGES; p++) begin
				if ((head_units[p] == 0) != (tail_units[p] == 0)) begin
					fc = pcpa_pkg::NCHUNKS - head_units[p] - tail_units[p];
					age = stamp_count - place_stamp[p];
					if (fc >= chunks && (!found || fc < best_fc ||
							(fc == best_fc && age < best_age))) begin
						found = 1;
						best = p;
						best_fc = fc;
						best_age = age;
					end
				end
			end
			if (!found) begin
				for (int p = 0; p < pcpa_pkg::NUM_PAGES; p++) begin
					if (!found && head_units[p] == 0 && tail_units[p] == 0) begin
						found = 1;
						best = p;
					end
				end
				if (found)
					used_pages++;
			end
			if (!found) begin
				r.status = pcpa_pkg::ST_NOMEM;
			end else begin
				r.status = pcpa_pkg::ST_OK;
				r.page_index = 6'(best);
				if (head_units[best] == 0) begin
					head_units[best] = chunks;
					r.half = 1'b0;
					r.byte_offset = 12'(pcpa_pkg::BLK_BYTES);
				end else begin
					tail_units[best] = chunks;
					r.half = 1'b1;
					r.byte_offset = 12'(pcpa_pkg::PAGE_SIZE_B - (chunks << pcpa_pkg::BLK_SHIFT));
				end
				if (head_units[best] == 0 || tail_units[best] == 0)
					stamp_page(best);
			end
		end
		r.pages_in_use = 7'(used_pages);
		return r;
	endfunction

	function alloc_result_t release_object(int p, bit h);
		alloc_result_t r;
		r = '0;
		if ((h ? tail_units[p] : head_units[p]) == 0) begin
			r.status = pcpa_pkg::ST_BADFREE;
		end else begin
			if (h)
				tail_units[p] = 0;
			else
				head_units[p] = 0;
			if (head_units[p] == 0 && tail_units[p] == 0)
				used_pages--;
			else
				stamp_page(p);
			r.status = pcpa_pkg::ST_OK;
		end
		r.pages_in_use = 7'(used_pages);
		return r;
	endfunction

	function void note_input(logic cmd, logic [23:0] data);
		if (cmd == pcpa_pkg::CMD_ALLOC)
			pending.push_back(place_object(data[15:0], data[16]));
		else
			pending.push_back(release_object(data[22:17], data[23]));
	endfunction

	task report(string what, int got, int want);
		$display("mismatch on result %0d: %s got %0d expected %0d", checked, what, got, want);
		errors++;
	endtask

	task check_result(logic [31:0] word);
		alloc_result_t got, want;
		got = word[28:0];
		if (pending.size() == 0) begin
			report("unexpected word", word, 0);
			return;
		end
		want = pending.pop_front();
		if (got.status !== want.status) report("status", got.status, want.status);
		if (got.page_index !== want.page_index)
			report("page_index", got.page_index, want.page_index);
		if (got.half !== want.half) report("half", got.half, want.half);
		if (got.byte_offset !== want.byte_offset)
			report("byte_offset", got.byte_offset, want.byte_offset);
		if (got.pages_in_use !== want.pages_in_use)
			report("pages_in_use", got.pages_in_use, want.pages_in_use);
		if (word[31:29] !== 3'b0) report("pad bits", word[31:29], 0);
		checked++;
	endtask
endclass

module tb_top;
	localparam int LIMIT = 2000000;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [23:0] s_tdata;
	logic        s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	logic [31:0] m_tdata;

	alloc_scoreboard board;
	bit quiet_phase;
	bit hold_out;
	int cycles;
	int n_alloc, n_free;

	paired_chunk_page_allocator_unit dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
	);

	initial begin
		clk = 0;
		forever #10 clk = ~clk;
	end

	initial begin
		cycles = 0;
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles > LIMIT) begin
				$display("timeout after %0d cycles", cycles);
				$display("[paired_chunk_page_allocator_unit] ERROR");
				$finish;
			end
		end
	end

	// Check words on the output side.
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			board.check_result(m_tdata);
	end

	// Output backpressure: random short stalls, plus one long hold-off.
	initial begin
		m_tready = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_out) begin
				m_tready <= 0;
				repeat (400) @(posedge clk);
				hold_out = 0;
			end else if (!quiet_phase && $urandom_range(0, 5) == 0) begin
				m_tready <= 0;
				repeat ($urandom_range(1, 3) - 1) @(posedge clk);
			end else begin
				m_tready <= 1;
			end
		end
	end

	task automatic send_word(logic cmd, logic [23:0] data);
		if (!quiet_phase && $urandom_range(0, 4) == 0) begin
			s_tvalid <= 0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		s_tvalid <= 1;
		s_tuser <= cmd;
		s_tdata <= data;
		do @(posedge clk); while (!s_tready);
		board.note_input(cmd, data);
		if (cmd == pcpa_pkg::CMD_ALLOC) n_alloc++; else n_free++;
	endtask

	task automatic send_alloc(int unsigned size, bit highmem);
		send_word(pcpa_pkg::CMD_ALLOC, {1'b0, 6'd0, highmem, size[15:0]});
	endtask

	task automatic send_free(int p, bit h);
		send_word(~pcpa_pkg::CMD_ALLOC, {h, p[5:0], 1'b0, 16'd0});
	endtask

	// Pick a sized request; mostly small to medium, some edges.
	function automatic int unsigned pick_size();
		case ($urandom_range(0, 9))
			0: return $urandom_range(pcpa_pkg::MAX_REQ - 64, pcpa_pkg::MAX_REQ);
			1: return $urandom_range(1, 64);
			2: return $urandom_range(pcpa_pkg::MAX_REQ + 1, 65535);
			default: return $urandom_range(1, 2048);
		endcase
	endfunction

	initial begin
		int p, h;
		board = new();
		board.clear();
		quiet_phase = 0;
		hold_out = 0;
		n_alloc = 0;
		n_free = 0;
		arst_n = 0;
		s_tvalid = 0;
		s_tdata = '0;
		s_tuser = pcpa_pkg::CMD_ALLOC;
		repeat (7) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// Directed: invalid sizes, highmem, oversize, chunk boundaries, bad frees.
		send_alloc(0, 0);
		send_alloc(100, 1);
		send_alloc(65535, 1);
		send_alloc(pcpa_pkg::MAX_REQ + 1, 0);
		send_alloc(65535, 0);
		send_free(0, 0);
		send_free(63, 1);
		send_alloc(1, 0);
		send_alloc(pcpa_pkg::MAX_REQ - 64, 0);
		send_alloc(pcpa_pkg::MAX_REQ, 0);
		send_alloc(64, 0);
		send_alloc(65, 0);
		send_alloc(2000, 0);
		send_alloc(1000, 0);
		send_free(0, 0);
		send_free(0, 0);
		send_free(0, 1);
		send_free(2, 0);
		send_alloc(1, 0);

		// Long output stall while input keeps coming.
		hold_out = 1;
		for (int i = 0; i < 8; i++) send_alloc(pick_size(), 0);

		// Random: phases alternately biased toward filling the pool and toward draining.
		for (int i = 0; i < 1400; i++) begin
			if (i == 1200) quiet_phase = 1;
			if ($urandom_range(0, 29) == 0) begin
				send_alloc($urandom_range(0, 65535), $urandom_range(0, 1));
			end else if ($urandom_range(0, 99) < (((i / 150) % 2) ? 30 : 70)) begin
				send_alloc(pick_size(), 0);
			end else begin
				// Mostly free a live half; sometimes a random one.
				p = $urandom_range(0, pcpa_pkg::NUM_PAGES - 1);
				h = $urandom_range(0, 1);
				if ($urandom_range(0, 7) != 0) begin
					for (int k = 0; k < pcpa_pkg::NUM_PAGES * 2; k++) begin
						if ((h ? board.tail_units[p] : board.head_units[p]) == 0) begin
							h = !h;
							if (h == 0) p = (p + 1) % pcpa_pkg::NUM_PAGES;
						end
					end
				end
				send_free(p, h);
			end
		end
		s_tvalid <= 0;

		while (board.pending.size() != 0) @(posedge clk);
		repeat (100) @(posedge clk);
		$display("%0d allocs and %0d frees, %0d results checked, %0d mismatches",
			n_alloc, n_free, board.checked, board.errors);
		if (board.errors == 0)
			$display("[paired_chunk_page_allocator_unit] OK");
		else
			$display("[paired_chunk_page_allocator_unit] ERROR");
		$finish;
	end
endmodule
`default_nettype wire
